[rtl/assert_macros.svh]
// Assertion helpers for the RTL files; only the top-level file includes them.
// They expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/chm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the convex hull block.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int unsigned COUNT_BITS = 11;  // holds counts up to 2047 points
  localparam int unsigned SIZE_BITS  = 7;
  localparam int unsigned OUT_BITS   = 32;
  localparam int unsigned TURN_PTS   = 3;   // points in one orientation test

  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic                  dropped;
  } job_t;

endpackage
`default_nettype wire

[rtl/chm_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chm_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module chm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/chm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chm_front
// Takes points, writes them to the point store, drops overflow and queues
// one hull job per set in a one-entry job queue.
// ----------------------------------------------------------------------------
module chm_front #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [31:0]                   point_x,
  input  wire logic [31:0]                   point_y,
  input  wire logic                          last_point,
  input  wire logic                          back_active,
  input  wire logic                          job_take,
  output      logic                          busy,
  output      logic                          st_we,
  output      logic [$clog2(MAX_POINTS)-1:0] st_waddr,
  output      logic [2*COORD_BITS-1:0]       st_wdata,
  output      logic                          job_valid,
  output      chm_pkg::job_t                 job
);
  import chm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 2);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          drop;
  logic          full;
  logic          accept;

  assign busy     = job_valid | back_active;
  assign accept   = start & ~busy;
  assign full     = (cnt >= CW'(MAX_POINTS));
  assign cnt_next = full ? cnt : cnt + 1'b1;

  assign st_we    = accept & ~full;
  assign st_waddr = cnt[AW-1:0];
  assign st_wdata = {point_x[COORD_BITS-1:0], point_y[COORD_BITS-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      drop      <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (last_point) begin
          job_valid   <= 1'b1;
          job.count   <= COUNT_BITS'(cnt_next);
          job.dropped <= drop | full;
          cnt         <= '0;
          drop        <= 1'b0;
        end else begin
          cnt  <= cnt_next;
          drop <= drop | full;
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/chm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chm_back
// Sorts the stored points, builds the lower and upper chains and streams
// the hull out counterclockwise.
// ----------------------------------------------------------------------------
module chm_back #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          job_valid,
  input  wire chm_pkg::job_t                 job,
  output      logic                          job_take,
  output      logic                          active,
  output      logic                          st_we,
  output      logic [$clog2(MAX_POINTS)-1:0] st_waddr,
  output      logic [2*COORD_BITS-1:0]       st_wdata,
  output      logic [$clog2(MAX_POINTS)-1:0] st_raddr,
  input  wire logic [2*COORD_BITS-1:0]       st_rdata,
  output      logic                          result_valid,
  output      logic [31:0]                   vertex_x,
  output      logic [31:0]                   vertex_y,
  output      logic [6:0]                    hull_size,
  output      logic                          last_vertex,
  output      logic                          overflow
);
  import chm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 2);
  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DW = 2 * COORD_BITS;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SI   = 4'd1;   // sort: next key
  localparam logic [3:0] S_SK   = 4'd2;   // sort: latch key
  localparam logic [3:0] S_SC   = 4'd3;   // sort: compare and shift
  localparam logic [3:0] S_SP   = 4'd4;   // sort: place key at 0
  localparam logic [3:0] S_CR   = 4'd5;   // chain: read next point
  localparam logic [3:0] S_CP   = 4'd6;   // chain: push
  localparam logic [3:0] S_O0   = 4'd7;   // orientation: differences
  localparam logic [3:0] S_O1   = 4'd8;   // orientation: products
  localparam logic [3:0] S_O2   = 4'd9;   // orientation: decide
  localparam logic [3:0] S_LD   = 4'd10;  // chain: reload third from top
  localparam logic [3:0] S_EM   = 4'd11;  // emit

  logic [3:0]               state;
  logic [CW-1:0]            cnt, i, j, top, ltop, size, k;
  logic                     drop, upper;
  logic [DW-1:0]            key, p1, p2, p3;
  logic signed [CB:0]       du, dv, dw, dz;
  logic signed [2*CB+1:0]   pm, qm;
  logic signed [2*CB+2:0]   sub;
  logic                     pop, gt, e_sel;
  logic [CW-1:0]            im1, jm2, tm2, tm4, smk, kp1;
  logic                     l_we, u_we;
  logic [AW-1:0]            ch_waddr, l_raddr, u_raddr;
  logic [DW-1:0]            ch_wdata, l_rdata, u_rdata, ch_rdata, v_sel;

  function automatic logic greater(input logic [DW-1:0] a, input logic [DW-1:0] b);
    logic signed [CB-1:0] ax, ay, bx, by;
    ax = a[DW-1:CB];
    ay = a[CB-1:0];
    bx = b[DW-1:CB];
    by = b[CB-1:0];
    return (ax > bx) || ((ax == bx) && (ay > by));
  endfunction

  assign im1 = i - 1'b1;
  assign jm2 = j - CW'(2);
  assign tm2 = top - CW'(2);
  assign tm4 = top - CW'(TURN_PTS + 1);
  assign smk = size - k;
  assign kp1 = k + 1'b1;

  assign sub = pm - qm;
  assign pop = upper ? (sub >= 0) : (sub <= 0);
  assign gt  = greater(st_rdata, key);
  assign ch_rdata = upper ? u_rdata : l_rdata;

  assign active   = (state != S_IDLE);
  assign job_take = (state == S_IDLE) & job_valid;

  always_comb begin
    st_we    = 1'b0;
    st_waddr = j[AW-1:0];
    st_wdata = key;
    st_raddr = i[AW-1:0];
    l_we     = 1'b0;
    u_we     = 1'b0;
    ch_waddr = top[AW-1:0];
    ch_wdata = st_rdata;
    l_raddr  = tm4[AW-1:0];
    u_raddr  = tm4[AW-1:0];
    case (state)
      S_SK: begin
        st_raddr = im1[AW-1:0];
      end
      S_SC: begin
        st_we = 1'b1;
        if (gt) begin
          st_wdata = st_rdata;
          st_raddr = jm2[AW-1:0];
        end
      end
      S_SP: begin
        st_we    = 1'b1;
        st_waddr = '0;
      end
      S_CP: begin
        l_we = ~upper;
        u_we = upper;
      end
      S_O2: begin
        if (pop) begin
          l_we     = ~upper;
          u_we     = upper;
          ch_waddr = tm2[AW-1:0];
          ch_wdata = p1;
        end
      end
      S_EM: begin
        l_raddr = k[AW-1:0];
        u_raddr = smk[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            cnt   <= CW'(job.count);
            drop  <= job.dropped;
            i     <= CW'(1);
            state <= S_SI;
          end
        end
        S_SI: begin
          if (i >= cnt) begin
            i     <= '0;
            top   <= '0;
            upper <= 1'b0;
            state <= S_CR;
          end else begin
            state <= S_SK;
          end
        end
        S_SK: begin
          key   <= st_rdata;
          j     <= i;
          state <= S_SC;
        end
        S_SC: begin
          if (gt) begin
            if (j == CW'(1)) begin
              j     <= '0;
              state <= S_SP;
            end else begin
              j <= j - 1'b1;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_SI;
          end
        end
        S_SP: begin
          i     <= i + 1'b1;
          state <= S_SI;
        end
        S_CR: begin
          if (i == cnt) begin
            if (!upper) begin
              ltop  <= top;
              upper <= 1'b1;
              i     <= '0;
              top   <= '0;
            end else begin
              // a lone point is its own hull
              size  <= (cnt == CW'(1)) ? CW'(1) : ltop + top - CW'(2);
              k     <= '0;
              state <= S_EM;
            end
          end else begin
            state <= S_CP;
          end
        end
        S_CP: begin
          p1    <= st_rdata;
          p2    <= p1;
          p3    <= p2;
          top   <= top + 1'b1;
          i     <= i + 1'b1;
          state <= (top >= CW'(TURN_PTS - 1)) ? S_O0 : S_CR;
        end
        S_O0: begin
          // a = p3, b = p2, c = p1
          du    <= (CB+1)'($signed(p2[DW-1:CB])) - (CB+1)'($signed(p3[DW-1:CB]));
          dv    <= (CB+1)'($signed(p1[CB-1:0])) - (CB+1)'($signed(p3[CB-1:0]));
          dw    <= (CB+1)'($signed(p2[CB-1:0])) - (CB+1)'($signed(p3[CB-1:0]));
          dz    <= (CB+1)'($signed(p1[DW-1:CB])) - (CB+1)'($signed(p3[DW-1:CB]));
          state <= S_O1;
        end
        S_O1: begin
          pm    <= du * dv;
          qm    <= dw * dz;
          state <= S_O2;
        end
        S_O2: begin
          if (pop) begin
            p2    <= p3;
            top   <= top - 1'b1;
            state <= (top >= CW'(TURN_PTS + 1)) ? S_LD : S_CR;
          end else begin
            state <= S_CR;
          end
        end
        S_LD: begin
          p3    <= ch_rdata;
          state <= S_O0;
        end
        S_EM: begin
          result_valid <= 1'b1;
          e_sel        <= (k >= ltop);
          last_vertex  <= (kp1 == size);
          hull_size    <= SIZE_BITS'(size);
          overflow     <= drop;
          k            <= kp1;
          if (kp1 == size) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign v_sel    = e_sel ? u_rdata : l_rdata;
  assign vertex_x = OUT_BITS'($signed(v_sel[DW-1:CB]));
  assign vertex_y = OUT_BITS'($signed(v_sel[CB-1:0]));

  chm_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_lower (
    .clk   (clk),
    .we    (l_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  chm_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_upper (
    .clk   (clk),
    .we    (u_we),
    .waddr (ch_waddr),
    .wdata (ch_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

endmodule
`default_nettype wire

[rtl/convex_hull_monotone_chain_top.sv]
`default_nettype none
// Points load at one per cycle while busy is low; the set's last point queues a job.
// Per set of points: an insertion sort over the single store port, then a lower and an upper
// chain pass, each with orientation tests on the stack top and a stack reload after a pop,
// then one vertex per cycle with no stall possible.
// busy stays high from the last point until the final vertex issues.
// Synchronous reset clears the point count, drop flag, job queue and sequencer.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// convex_hull_monotone_chain_top
// Convex hull by monotone chain: point loader, job queue and hull engine.
// ----------------------------------------------------------------------------
module convex_hull_monotone_chain_top #(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] point_x,
  input  wire logic [31:0] point_y,
  input  wire logic        last_point,
  output      logic        result_valid,
  output      logic [31:0] vertex_x,
  output      logic [31:0] vertex_y,
  output      logic [6:0]  hull_size,
  output      logic        last_vertex,
  output      logic        overflow
);
  import chm_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned DW = 2 * COORD_BITS;

  logic          back_active, job_valid, job_take;
  job_t          job;
  logic          f_we, b_we, st_we;
  logic [AW-1:0] f_waddr, b_waddr, st_waddr, st_raddr;
  logic [DW-1:0] f_wdata, b_wdata, st_wdata, st_rdata;

  chm_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .point_x     (point_x),
    .point_y     (point_y),
    .last_point  (last_point),
    .back_active (back_active),
    .job_take    (job_take),
    .busy        (busy),
    .st_we       (f_we),
    .st_waddr    (f_waddr),
    .st_wdata    (f_wdata),
    .job_valid   (job_valid),
    .job         (job)
  );

  // store belongs to the engine while it runs
  assign st_we    = back_active ? b_we    : f_we;
  assign st_waddr = back_active ? b_waddr : f_waddr;
  assign st_wdata = back_active ? b_wdata : f_wdata;

  chm_ram #(.WIDTH(DW), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  chm_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_valid    (job_valid),
    .job          (job),
    .job_take     (job_take),
    .active       (back_active),
    .st_we        (b_we),
    .st_waddr     (b_waddr),
    .st_wdata     (b_wdata),
    .st_raddr     (st_raddr),
    .st_rdata     (st_rdata),
    .result_valid (result_valid),
    .vertex_x     (vertex_x),
    .vertex_y     (vertex_y),
    .hull_size    (hull_size),
    .last_vertex  (last_vertex),
    .overflow     (overflow)
  );

  `CHK_NEXT(a_last_ends_burst, result_valid && last_vertex, !result_valid, "vertex after last")
  `CHK_NEXT(a_burst_steady, result_valid && !last_vertex, result_valid && $stable(hull_size) && $stable(overflow), "hull burst broken")
  `CHK_IMPLY(a_busy_in_burst, result_valid && !last_vertex, busy, "ready during emission")
  `CHK_IMPLY(a_size_nonzero, result_valid, hull_size != 7'd0, "empty hull emitted")

endmodule
`default_nettype wire
